// File: rtl/ffha_pkg.sv
// shared types, constants and helpers of the first-fit heap allocator
package ffha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 16;
   localparam int HDR          = (HEADER_BYTES + 7) / 8 * 8;
   localparam int GRANULES     = HEAP_BYTES / 8;
   localparam int CAP          = GRANULES * 8;
   localparam int IDX_W        = $clog2(GRANULES);

   localparam logic [2:0] KIND_ALLOC   = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_RESIZE  = 3'd2;
   localparam logic [2:0] KIND_ARRAY   = 3'd3;
   localparam logic [2:0] KIND_AUDIT   = 3'd4;
   localparam logic [2:0] KIND_PEAKS   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_NOFIT = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   typedef struct packed {
      logic [16:0] size;
      logic [16:0] back;
      logic        taken;
   } hdr_type;

   typedef struct packed {
      logic             re;
      logic [IDX_W-1:0] raddr;
      logic             we;
      logic             back_only;
      logic [IDX_W-1:0] waddr;
      hdr_type          wdata;
   } mem_req_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_SIZE, S_LOC, S_LOC_CHK, S_LOC_DONE,
      S_RSZ, S_RSZ_CHK, S_RSZ_FIT, S_WALK_RD, S_WALK_CHK,
      S_CARVE, S_CARVE_Q, S_CARVE_R, S_MG_RD, S_MG_CHK, S_MG_CLR, S_MG_BK,
      S_POST, S_PEAK, S_REL_RD, S_REL_CHK, S_REL_PREV, S_REL_PCHK,
      S_AUD_RD, S_AUD_CHK, S_RESP
   } state_type;

   localparam hdr_type INIT_HDR = '{size: 17'(CAP - HDR), back: 17'd0, taken: 1'b0};

   function automatic logic [IDX_W-1:0] gran(input logic [17:0] off);
      return off[IDX_W+2:3];
   endfunction

endpackage

// File: rtl/ffha_mem.sv
// header store: one header per granule, registered read, field write for back distance
module ffha_mem (
   input  logic                 clock,
   input  ffha_pkg::mem_req_type req,
   output ffha_pkg::hdr_type    rdata
);
   import ffha_pkg::*;

   hdr_type mem_ff [GRANULES];
   hdr_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         if (req.back_only) begin
            mem_ff[req.waddr].back <= req.wdata.back;
         end else begin
            mem_ff[req.waddr] <= req.wdata;
         end
      end
      if (req.re) begin
         rdata_ff <= mem_ff[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/first_fit_heap_allocator.sv
// first-fit heap allocator: request sequencer over the header store
// throughput: one request at a time, busy stays high from transfer until the result strobe
// the result is shown for one cycle with rsp_valid and cannot be stalled
// reset: a clearing pass writes all 8192 headers, one per cycle, while busy is high
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_element_count,
   input  logic [15:0] req_payload_offset,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_in_place,
   output logic [16:0] rsp_bytes_in_use,
   output logic [12:0] rsp_total_blocks,
   output logic [16:0] rsp_peak_in_use,
   output logic [16:0] rsp_peak_occupied_bytes,
   output logic [16:0] rsp_free_total,
   output logic [16:0] rsp_largest_free_block,
   output logic [12:0] rsp_free_block_count,
   output logic [15:0] rsp_failures_seen
);
   import ffha_pkg::*;

   localparam logic [17:0] CAP_X = 18'(CAP);
   localparam logic [17:0] HDR_X = 18'(HDR);

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] rs_ff, rs_in, cnt_ff, cnt_in;
   logic [15:0] po_ff, po_in;
   logic [63:0] z_ff, z_in;
   logic [18:0] need_ff, need_in;
   logic [16:0] cur_ff, cur_in, nxt_ff, nxt_in, blk_ff, blk_in;
   logic [16:0] old_ff, old_in, fin_ff, fin_in;
   hdr_type     curh_ff, curh_in;
   logic        loc_ff, loc_in, inpl_ff, inpl_in, wf_ff, wf_in;
   logic [15:0] res_ff, res_in;
   logic [1:0]  st_ff, st_in;
   logic [16:0] ft_ff, ft_in, lg_ff, lg_in, prev_ff, prev_in, live_ff, live_in;
   logic [12:0] fc_ff, fc_in, cntb_ff, cntb_in;
   logic [16:0] used_ff, used_in, peak_live_ff, peak_live_in, peak_occ_ff, peak_occ_in;
   logic [12:0] total_ff, total_in;
   logic [15:0] fail_ff, fail_in;

   mem_req_type mreq;
   hdr_type     rdata;

   logic [17:0] cur_end, rd_end, old_end, occ, aud_room;
   logic [16:0] loc_off, split_diff, mg_size;
   logic [18:0] grow;

   ffha_mem u_mem (
      .clock (clock),
      .req   (mreq),
      .rdata (rdata)
   );

   assign cur_end    = 18'(cur_ff) + HDR_X + 18'(curh_ff.size);
   assign rd_end     = 18'(cur_ff) + HDR_X + 18'(rdata.size);
   assign old_end    = 18'(cur_ff) + HDR_X + 18'(old_ff);
   assign occ        = 18'(used_ff) + 18'(total_ff) * HDR_X;
   assign aud_room   = CAP_X - 18'(cur_ff) - HDR_X;
   assign loc_off    = 17'(po_ff) - 17'(HDR);
   assign split_diff = curh_ff.size - need_ff[16:0];
   assign mg_size    = curh_ff.size + 17'(HDR) + rdata.size;
   assign grow       = 19'(old_ff) + 19'(HDR) + 19'(rdata.size);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         total_ff     <= 13'd1;
         peak_live_ff <= '0;
         peak_occ_ff  <= '0;
         fail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         peak_live_ff <= peak_live_in;
         peak_occ_ff  <= peak_occ_in;
         fail_ff      <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      kind_ff <= kind_in;
      rs_ff   <= rs_in;
      cnt_ff  <= cnt_in;
      po_ff   <= po_in;
      z_ff    <= z_in;
      need_ff <= need_in;
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
      blk_ff  <= blk_in;
      old_ff  <= old_in;
      fin_ff  <= fin_in;
      curh_ff <= curh_in;
      loc_ff  <= loc_in;
      inpl_ff <= inpl_in;
      wf_ff   <= wf_in;
      res_ff  <= res_in;
      st_ff   <= st_in;
      ft_ff   <= ft_in;
      lg_ff   <= lg_in;
      fc_ff   <= fc_in;
      prev_ff <= prev_in;
      live_ff <= live_in;
      cntb_ff <= cntb_in;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      rs_in        = rs_ff;
      cnt_in       = cnt_ff;
      po_in        = po_ff;
      z_in         = z_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      blk_in       = blk_ff;
      old_in       = old_ff;
      fin_in       = fin_ff;
      curh_in      = curh_ff;
      loc_in       = loc_ff;
      inpl_in      = inpl_ff;
      wf_in        = wf_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      ft_in        = ft_ff;
      lg_in        = lg_ff;
      fc_in        = fc_ff;
      prev_in      = prev_ff;
      live_in      = live_ff;
      cntb_in      = cntb_ff;
      used_in      = used_ff;
      total_in     = total_ff;
      peak_live_in = peak_live_ff;
      peak_occ_in  = peak_occ_ff;
      fail_in      = fail_ff;
      mreq         = '0;
      rsp_valid    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mreq.we    = 1'b1;
            mreq.waddr = clr_ff;
            mreq.wdata = (clr_ff == '0) ? INIT_HDR : '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(GRANULES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               rs_in    = req_request_size;
               cnt_in   = req_element_count;
               po_in    = req_payload_offset;
               res_in   = '0;
               st_in    = ST_OK;
               inpl_in  = 1'b0;
               loc_in   = 1'b0;
               ft_in    = '0;
               lg_in    = '0;
               fc_in    = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (kind_ff)
               KIND_ALLOC, KIND_RESIZE: begin
                  z_in     = {32'd0, rs_ff};
                  state_in = S_SIZE;
               end
               KIND_ARRAY: begin
                  z_in     = {32'd0, rs_ff} * {32'd0, cnt_ff};
                  state_in = S_SIZE;
               end
               KIND_RELEASE: begin
                  state_in = S_LOC;
               end
               KIND_AUDIT: begin
                  cur_in   = '0;
                  prev_in  = '0;
                  live_in  = '0;
                  cntb_in  = '0;
                  wf_in    = 1'b0;
                  state_in = S_AUD_RD;
               end
               KIND_PEAKS: begin
                  peak_live_in = used_ff;
                  peak_occ_in  = occ[16:0];
                  state_in     = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SIZE: begin
            need_in = (|z_ff[63:17]) ? '1 : ((19'(z_ff[16:0]) + 19'd7) & ~19'd7);
            if (kind_ff == KIND_RESIZE) begin
               state_in = S_LOC;
            end else if (z_ff == '0) begin
               st_in    = ST_ZERO;
               state_in = S_RESP;
            end else begin
               cur_in   = '0;
               state_in = S_WALK_RD;
            end
         end
         S_LOC: begin
            if (po_ff == '0) begin
               state_in = S_LOC_DONE;
            end else if (17'(po_ff) < 17'(HDR) || loc_off[2:0] != 3'd0 ||
                         18'(loc_off) >= CAP_X) begin
               st_in    = ST_BAD;
               state_in = S_RESP;
            end else begin
               mreq.re    = 1'b1;
               mreq.raddr = gran(18'(loc_off));
               cur_in     = loc_off;
               state_in   = S_LOC_CHK;
            end
         end
         S_LOC_CHK: begin
            if (rdata.size == '0 || !rdata.taken) begin
               st_in    = ST_BAD;
               state_in = S_RESP;
            end else begin
               curh_in  = rdata;
               blk_in   = cur_ff;
               old_in   = rdata.size;
               loc_in   = 1'b1;
               state_in = S_LOC_DONE;
            end
         end
         S_LOC_DONE: begin
            if (kind_ff == KIND_RELEASE) begin
               state_in = loc_ff ? S_REL_RD : S_RESP;
            end else if (z_ff == '0) begin
               st_in    = ST_ZERO;
               state_in = loc_ff ? S_REL_RD : S_RESP;
            end else if (loc_ff) begin
               state_in = S_RSZ;
            end else begin
               cur_in   = '0;
               state_in = S_WALK_RD;
            end
         end
         S_RSZ: begin
            if (19'(old_ff) < need_ff && old_end < CAP_X) begin
               mreq.re    = 1'b1;
               mreq.raddr = gran(old_end);
               state_in   = S_RSZ_CHK;
            end else begin
               state_in = S_RSZ_FIT;
            end
         end
         S_RSZ_CHK: begin
            if (!rdata.taken && grow >= need_ff) begin
               ret_in   = S_RSZ_FIT;
               state_in = S_MG_RD;
            end else begin
               state_in = S_RSZ_FIT;
            end
         end
         S_RSZ_FIT: begin
            if (19'(curh_ff.size) >= need_ff) begin
               inpl_in  = 1'b1;
               state_in = S_CARVE;
            end else begin
               cur_in   = '0;
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            mreq.re    = 1'b1;
            mreq.raddr = gran(18'(cur_ff));
            state_in   = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            curh_in = rdata;
            if (!rdata.taken && rdata.size != '0 && 19'(rdata.size) >= need_ff) begin
               state_in = S_CARVE;
            end else if (rd_end >= CAP_X) begin
               st_in    = ST_NOFIT;
               if (fail_ff != '1) begin
                  fail_in = fail_ff + 1'b1;
               end
               state_in = S_RESP;
            end else begin
               cur_in   = rd_end[16:0];
               state_in = S_WALK_RD;
            end
         end
         S_CARVE: begin
            mreq.we    = 1'b1;
            mreq.waddr = gran(18'(cur_ff));
            res_in     = 16'(18'(cur_ff) + HDR_X);
            if (split_diff < 17'(HDR + 8)) begin
               mreq.wdata = '{size: curh_ff.size, back: curh_ff.back, taken: 1'b1};
               fin_in     = curh_ff.size;
               state_in   = S_POST;
            end else begin
               mreq.wdata = '{size: need_ff[16:0], back: curh_ff.back, taken: 1'b1};
               fin_in     = need_ff[16:0];
               cur_in     = 17'(18'(cur_ff) + HDR_X + 18'(need_ff[16:0]));
               curh_in    = '{size: split_diff - 17'(HDR),
                              back: 17'(HDR) + need_ff[16:0], taken: 1'b0};
               state_in   = S_CARVE_Q;
            end
         end
         S_CARVE_Q: begin
            mreq.we    = 1'b1;
            mreq.waddr = gran(18'(cur_ff));
            mreq.wdata = curh_ff;
            total_in   = total_ff + 1'b1;
            ret_in     = S_POST;
            if (cur_end < CAP_X) begin
               nxt_in   = cur_end[16:0];
               state_in = S_CARVE_R;
            end else begin
               state_in = S_MG_RD;
            end
         end
         S_CARVE_R: begin
            mreq.we         = 1'b1;
            mreq.back_only  = 1'b1;
            mreq.waddr      = gran(18'(nxt_ff));
            mreq.wdata.back = curh_ff.size + 17'(HDR);
            state_in        = S_MG_RD;
         end
         S_MG_RD: begin
            if (cur_end >= CAP_X) begin
               state_in = ret_ff;
            end else begin
               mreq.re    = 1'b1;
               mreq.raddr = gran(cur_end);
               nxt_in     = cur_end[16:0];
               state_in   = S_MG_CHK;
            end
         end
         S_MG_CHK: begin
            if (rdata.taken) begin
               state_in = ret_ff;
            end else begin
               mreq.we      = 1'b1;
               mreq.waddr   = gran(18'(cur_ff));
               mreq.wdata   = '{size: mg_size, back: curh_ff.back, taken: curh_ff.taken};
               curh_in.size = mg_size;
               state_in     = S_MG_CLR;
            end
         end
         S_MG_CLR: begin
            mreq.we    = 1'b1;
            mreq.waddr = gran(18'(nxt_ff));
            mreq.wdata = '0;
            total_in   = total_ff - 1'b1;
            if (cur_end < CAP_X) begin
               nxt_in   = cur_end[16:0];
               state_in = S_MG_BK;
            end else begin
               state_in = ret_ff;
            end
         end
         S_MG_BK: begin
            mreq.we         = 1'b1;
            mreq.back_only  = 1'b1;
            mreq.waddr      = gran(18'(nxt_ff));
            mreq.wdata.back = curh_ff.size + 17'(HDR);
            state_in        = ret_ff;
         end
         S_POST: begin
            if (inpl_ff) begin
               used_in = used_ff - old_ff + fin_ff;
            end else begin
               used_in = used_ff + fin_ff;
            end
            state_in = S_PEAK;
         end
         S_PEAK: begin
            if (used_ff > peak_live_ff) begin
               peak_live_in = used_ff;
            end
            if (occ > 18'(peak_occ_ff)) begin
               peak_occ_in = occ[16:0];
            end
            if (!inpl_ff && kind_ff == KIND_RESIZE && loc_ff) begin
               cur_in   = blk_ff;
               state_in = S_REL_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_REL_RD: begin
            mreq.re    = 1'b1;
            mreq.raddr = gran(18'(cur_ff));
            state_in   = S_REL_CHK;
         end
         S_REL_CHK: begin
            used_in    = used_ff - rdata.size;
            curh_in    = '{size: rdata.size, back: rdata.back, taken: 1'b0};
            mreq.we    = 1'b1;
            mreq.waddr = gran(18'(cur_ff));
            mreq.wdata = '{size: rdata.size, back: rdata.back, taken: 1'b0};
            ret_in     = S_REL_PREV;
            state_in   = S_MG_RD;
         end
         S_REL_PREV: begin
            if (curh_ff.back != '0 && curh_ff.back <= cur_ff) begin
               mreq.re    = 1'b1;
               mreq.raddr = gran(18'(cur_ff - curh_ff.back));
               cur_in     = cur_ff - curh_ff.back;
               state_in   = S_REL_PCHK;
            end else begin
               state_in = S_RESP;
            end
         end
         S_REL_PCHK: begin
            if (!rdata.taken) begin
               curh_in  = rdata;
               ret_in   = S_RESP;
               state_in = S_MG_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_AUD_RD: begin
            if (18'(cur_ff) < CAP_X) begin
               if (CAP_X - 18'(cur_ff) < HDR_X) begin
                  st_in    = ST_BAD;
                  ft_in    = '0;
                  lg_in    = '0;
                  fc_in    = '0;
                  state_in = S_RESP;
               end else begin
                  mreq.re    = 1'b1;
                  mreq.raddr = gran(18'(cur_ff));
                  state_in   = S_AUD_CHK;
               end
            end else begin
               if (!(live_ff == used_ff && cntb_ff == total_ff && 18'(cur_ff) == CAP_X)) begin
                  st_in = ST_BAD;
                  ft_in = '0;
                  lg_in = '0;
                  fc_in = '0;
               end
               state_in = S_RESP;
            end
         end
         S_AUD_CHK: begin
            if (rdata.size[2:0] != 3'd0 || rdata.size == '0 || 18'(rdata.size) > aud_room ||
                rdata.back != prev_ff || (!rdata.taken && wf_ff)) begin
               st_in    = ST_BAD;
               ft_in    = '0;
               lg_in    = '0;
               fc_in    = '0;
               state_in = S_RESP;
            end else begin
               if (rdata.taken) begin
                  live_in = live_ff + rdata.size;
                  wf_in   = 1'b0;
               end else begin
                  ft_in = ft_ff + rdata.size;
                  fc_in = fc_ff + 1'b1;
                  wf_in = 1'b1;
                  if (rdata.size > lg_ff) begin
                     lg_in = rdata.size;
                  end
               end
               cntb_in  = cntb_ff + 1'b1;
               prev_in  = rdata.size + 17'(HDR);
               cur_in   = rd_end[16:0];
               state_in = S_AUD_RD;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy                    = (state_ff != S_IDLE);
   assign rsp_result_offset       = res_ff;
   assign rsp_status              = st_ff;
   assign rsp_in_place            = inpl_ff;
   assign rsp_bytes_in_use        = used_ff;
   assign rsp_total_blocks        = total_ff;
   assign rsp_peak_in_use         = peak_live_ff;
   assign rsp_peak_occupied_bytes = peak_occ_ff;
   assign rsp_free_total          = ft_ff;
   assign rsp_largest_free_block  = lg_ff;
   assign rsp_free_block_count    = fc_ff;
   assign rsp_failures_seen       = fail_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held longer than one cycle");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> peak_live_ff >= used_ff) else $error("peak below bytes in use");

   a_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> total_ff != '0) else $error("block count reached zero");

   a_fail_sat: assert property (@(posedge clock) disable iff (reset)
      fail_ff == '1 |=> fail_ff == '1) else $error("failure counter wrapped");

   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      mreq.re |-> !mreq.we) else $error("header read and write in the same cycle");

endmodule
